@@ rtl/sorted_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_macros
// Assertion helpers for the sorted priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SPQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define SPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: next-cycle check failed");

`endif

@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam int PRI_W = 8;
    localparam int TAG_W = 16;
    localparam int CNT_OUT_W = 5;

    // One input transaction
    typedef struct packed {
        t_opcode           opcode;
        logic [PRI_W-1:0]  new_priority;
        logic [TAG_W-1:0]  new_tag;
    } t_in;

    // One result transaction
    typedef struct packed {
        t_status               status;
        logic [PRI_W-1:0]      removed_priority;
        logic [TAG_W-1:0]      removed_tag;
        logic                  head_valid;
        logic [PRI_W-1:0]      head_priority;
        logic [TAG_W-1:0]      head_tag;
        logic [CNT_OUT_W-1:0]  entry_count;
    } t_out;

    // Content of one cell
    typedef struct packed {
        logic              valid;
        logic [PRI_W-1:0]  pri;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // Broadcast control from the queue front end to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [PRI_W-1:0]  pri;
        logic [TAG_W-1:0]  tag;
    } t_cell_ctl;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and either keeps it, takes
// the new entry, takes its left neighbor (insert) or its right neighbor
// (remove).
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry   i_prev,
    input  logic              i_prev_keep,
    input  spq_pkg::t_entry   i_next,
    output spq_pkg::t_entry   o_entry,
    output logic              o_keep
);
    import spq_pkg::*;

    logic              r_valid;
    logic [PRI_W-1:0]  r_pri;
    logic [TAG_W-1:0]  r_tag;
    logic              n_valid;
    logic [PRI_W-1:0]  n_pri;
    logic [TAG_W-1:0]  n_tag;

    assign o_entry = '{valid: r_valid, pri: r_pri, tag: r_tag};

    // Entry stays put when it is at least as urgent as the new one
    assign o_keep = r_valid && (r_pri <= i_ctl.pri);

    // Next content
    always_comb begin
        n_valid = r_valid;
        n_pri   = r_pri;
        n_tag   = r_tag;
        if (i_ctl.ins) begin
            if (o_keep) begin
                n_valid = r_valid;
            end else if (i_prev_keep) begin
                n_valid = 1'b1;
                n_pri   = i_ctl.pri;
                n_tag   = i_ctl.tag;
            end else begin
                n_valid = i_prev.valid;
                n_pri   = i_prev.pri;
                n_tag   = i_prev.tag;
            end
        end else if (i_ctl.rem) begin
            n_valid = i_next.valid;
            n_pri   = i_next.pri;
            n_tag   = i_next.tag;
        end
    end

    // Occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_tag <= n_tag;
    end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of DEPTH cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   per transaction: insert an entry (priority, tag) or remove the head.
//   Lower priority numbers are more urgent; equal priorities leave in
//   arrival order.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result per command: status, the removed entry (zero if none), the
//   head after the command (zero when empty) and the entry count.
//   The result is registered and presented in the cycle after the command is taken.
//   Throughput: one command per cycle while the receiver does not stall. All
//   cells compare against the new priority in parallel and shift by one slot
//   in the same cycle. A full insert is rejected (status full), a remove on an
//   empty queue is flagged (status empty); neither changes the contents.
//   Reset clears the count and every cell's occupancy bit.
//   While the receiver stalls a pending result, the result register holds and
//   o_in_stall is raised, so no further command is taken until the result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic            r_out_valid;
    t_out            r_out_data;
    t_out            n_out_data;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    t_cell_ctl       w_ctl;
    t_entry          w_cell [DEPTH];
    logic            w_keep [DEPTH];
    logic [DEPTH-1:0] w_valid_vec;
    logic [DEPTH-2:0] w_order;
    t_entry          w_head;

    // Handshake
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // Command broadcast to the chain
    always_comb begin
        w_ctl.ins = w_accept && (i_in_data.opcode == OP_INSERT) && !w_full;
        w_ctl.rem = w_accept && (i_in_data.opcode == OP_REMOVE) && !w_empty;
        w_ctl.pri = i_in_data.new_priority;
        w_ctl.tag = i_in_data.new_tag;
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_keep;

        if (g == 0) begin : g_first
            assign w_prev      = '0;
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev      = w_cell[g-1];
            assign w_prev_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_cell[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev      (w_prev),
            .i_prev_keep (w_prev_keep),
            .i_next      (w_next),
            .o_entry     (w_cell[g]),
            .o_keep      (w_keep[g])
        );

        assign w_valid_vec[g] = w_cell[g].valid;
    end

    // Sorted-order flags for checking
    for (genvar g = 0; g < DEPTH - 1; g++) begin : g_order
        assign w_order[g] = !w_cell[g+1].valid || (w_cell[g].pri <= w_cell[g+1].pri);
    end

    // Head after this command
    always_comb begin
        w_head = w_cell[0];
        if (w_ctl.ins) begin
            if (!w_keep[0]) begin
                w_head = '{valid: 1'b1, pri: w_ctl.pri, tag: w_ctl.tag};
            end
        end else if (w_ctl.rem) begin
            w_head = w_cell[1];
        end
    end

    // Count and result
    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.rem) begin
            n_count = r_count - 1'b1;
        end

        n_out_data                  = '0;
        n_out_data.status           = ST_DONE;
        if (i_in_data.opcode == OP_INSERT) begin
            if (w_full) begin
                n_out_data.status = ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_out_data.status = ST_EMPTY;
            end else begin
                n_out_data.removed_priority = w_cell[0].pri;
                n_out_data.removed_tag      = w_cell[0].tag;
            end
        end
        if (w_head.valid) begin
            n_out_data.head_valid    = 1'b1;
            n_out_data.head_priority = w_head.pri;
            n_out_data.head_tag      = w_head.tag;
        end
        n_out_data.entry_count = CNT_OUT_W'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    // Checks
    `include "sorted_priority_queue_macros.svh"

    `SPQ_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `SPQ_ASSERT_IMPL(a_count_cells, i_clk, i_rst_n, 1'b1, $countones(w_valid_vec) == int'(r_count))
    `SPQ_ASSERT_IMPL(a_sorted, i_clk, i_rst_n, 1'b1, &w_order)
    `SPQ_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_ctl.ins, r_count == $past(r_count) + 1'b1)
    `SPQ_ASSERT_NEXT(a_rem_head, i_clk, i_rst_n, w_ctl.rem, r_out_data.removed_tag == $past(w_cell[0].tag))

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue.
// Commands go in over the valid/stall input channel. A shadow of the sorted
// queue predicts results the table does not give; each result is checked
// field by field in arrival order. The run starts with a table of hand-picked
// commands: empty and full queues, extreme priorities and tags, and ties.
// Random segments follow, with fill-heavy and drain-heavy command mixes,
// several idle and stall patterns, and long receiver hold-offs that back the
// queue up.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int N_SEGMENTS     = 8;
    localparam int SEG_ITEMS      = 100;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Idle patterns, one per random segment in turn
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One row of the directed table
    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out want;
    } t_plan_row;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out_data;

    // Shadow of the sorted queue contents
    logic [PRI_W-1:0] shadow_pri [QDEPTH];
    logic [TAG_W-1:0] shadow_tag [QDEPTH];
    int               shadow_len = 0;

    t_out      pending_results [$];
    t_plan_row directed_plan [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    int  hold_left      = 0;
    bit  run_done       = 1'b0;
    int  quiet_cycles   = 0;

    int  error_count    = 0;
    int  cmds_sent      = 0;
    int  results_seen   = 0;
    int  full_seen      = 0;
    int  empty_seen     = 0;
    int  backed_up      = 0;

    sorted_priority_queue #(
        .DEPTH(QDEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Update the shadow queue with one command and return the result it gives
    function automatic t_out advance_shadow_queue(t_in cmd);
        t_out r;
        int   pos;
        r = '0;
        r.status = ST_DONE;
        if (cmd.opcode == OP_INSERT) begin
            if (shadow_len >= QDEPTH) begin
                r.status = ST_FULL;
            end else begin
                // equal priorities stay in arrival order
                pos = 0;
                while (pos < shadow_len && shadow_pri[pos] <= cmd.new_priority)
                    pos++;
                for (int i = shadow_len; i > pos; i--) begin
                    shadow_pri[i] = shadow_pri[i-1];
                    shadow_tag[i] = shadow_tag[i-1];
                end
                shadow_pri[pos] = cmd.new_priority;
                shadow_tag[pos] = cmd.new_tag;
                shadow_len++;
            end
        end else begin
            if (shadow_len == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_priority = shadow_pri[0];
                r.removed_tag      = shadow_tag[0];
                for (int i = 0; i + 1 < shadow_len; i++) begin
                    shadow_pri[i] = shadow_pri[i+1];
                    shadow_tag[i] = shadow_tag[i+1];
                end
                shadow_len--;
            end
        end
        if (shadow_len > 0) begin
            r.head_valid    = 1'b1;
            r.head_priority = shadow_pri[0];
            r.head_tag      = shadow_tag[0];
        end
        r.entry_count = CNT_OUT_W'(shadow_len);
        return r;
    endfunction

    // Random command; priorities often crowd the ends to force ties
    function automatic t_in random_cmd(int insert_pct);
        t_in c;
        c.opcode = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(3))
            0: c.new_priority = PRI_W'($urandom_range(3));
            1: c.new_priority = PRI_W'($urandom_range(255, 252));
            default: c.new_priority = PRI_W'($urandom_range(255));
        endcase
        c.new_tag = TAG_W'($urandom_range(65535));
        return c;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic plan_row(t_opcode op, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag,
                            bit typed, t_out want);
        t_plan_row row;
        row.cmd.opcode       = op;
        row.cmd.new_priority = pri;
        row.cmd.new_tag      = tag;
        row.typed            = typed;
        row.want             = want;
        directed_plan.push_back(row);
    endtask

    // Offer one command transaction, hold it until taken, then predict it
    task automatic offer(t_in cmd, bit typed, t_out want);
        t_out predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall);
        predicted = advance_shadow_queue(cmd);
        pending_results.push_back(typed ? want : predicted);
        cmds_sent++;
    endtask

    // Receiver: random stall, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_out_data.status == ST_FULL) full_seen++;
            if (o_out_data.status == ST_EMPTY) empty_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_out_data.entry_count), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status != want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.removed_priority != want.removed_priority)
                    report_mismatch("removed_priority", 32'(o_out_data.removed_priority),
                                    32'(want.removed_priority));
                if (o_out_data.removed_tag != want.removed_tag)
                    report_mismatch("removed_tag", 32'(o_out_data.removed_tag),
                                    32'(want.removed_tag));
                if (o_out_data.head_valid != want.head_valid)
                    report_mismatch("head_valid", 32'(o_out_data.head_valid),
                                    32'(want.head_valid));
                if (o_out_data.head_priority != want.head_priority)
                    report_mismatch("head_priority", 32'(o_out_data.head_priority),
                                    32'(want.head_priority));
                if (o_out_data.head_tag != want.head_tag)
                    report_mismatch("head_tag", 32'(o_out_data.head_tag),
                                    32'(want.head_tag));
                if (o_out_data.entry_count != want.entry_count)
                    report_mismatch("entry_count", 32'(o_out_data.entry_count),
                                    32'(want.entry_count));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!run_done) begin
            if (i_in_valid && o_in_stall) backed_up++;
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_idle_mode mode;
        int         insert_bias [N_SEGMENTS];
        insert_bias = '{80, 20, 55, 95, 85, 10, 60, 30};

        // Directed table: empty, ties, fill to full, reject, then a remove and an insert
        plan_row(OP_REMOVE, 8'hff, 16'hffff, 1'b1,
                 '{ST_EMPTY, 8'd0, 16'd0, 1'b0, 8'd0, 16'd0, 5'd0});
        plan_row(OP_INSERT, 8'hff, 16'hffff, 1'b1,
                 '{ST_DONE, 8'd0, 16'd0, 1'b1, 8'hff, 16'hffff, 5'd1});
        plan_row(OP_INSERT, 8'h00, 16'h0000, 1'b1,
                 '{ST_DONE, 8'd0, 16'd0, 1'b1, 8'h00, 16'h0000, 5'd2});
        plan_row(OP_INSERT, 8'hff, 16'h1234, 1'b0, '0);
        plan_row(OP_INSERT, 8'h00, 16'h8001, 1'b0, '0);
        plan_row(OP_REMOVE, 8'h5a, 16'h5a5a, 1'b1,
                 '{ST_DONE, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h8001, 5'd3});
        for (int k = 1; k <= 13; k++)
            plan_row(OP_INSERT, 8'h80 ^ PRI_W'(k % 3), TAG_W'(k), 1'b0, '0);
        plan_row(OP_INSERT, 8'h00, 16'haaaa, 1'b1,
                 '{ST_FULL, 8'd0, 16'd0, 1'b1, 8'h00, 16'h8001, 5'd16});
        plan_row(OP_REMOVE, 8'h00, 16'h0000, 1'b0, '0);
        plan_row(OP_INSERT, 8'hff, 16'h7fff, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[n])
            offer(directed_plan[n].cmd, directed_plan[n].typed, directed_plan[n].want);

        // Random segments, each with its own command mix and idle pattern
        for (int s = 0; s < N_SEGMENTS; s++) begin
            mode = t_idle_mode'(s % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default:       begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            // back the queue up while commands keep coming
            if (mode == IDLE_NONE) hold_req = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
                offer(random_cmd(insert_bias[s]), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        run_done = 1'b1;

        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("covered %0d commands and %0d results, %0d full rejects, %0d empty removes",
                 cmds_sent, results_seen, full_seen, empty_seen);
        $display("input held off for %0d cycles, %0d mismatches", backed_up, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/tb.sv
